>>> rtl/pcnf_pkg.sv
`default_nettype none
package pcnf_pkg;

  localparam int unsigned IDX_W      = 20;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned DIV_W      = 64;

  localparam logic [2:0] CFG_LOADING_STIFFNESS       = 3'd0;
  localparam logic [2:0] CFG_UNLOADING_STIFFNESS_MAX = 3'd1;
  localparam logic [2:0] CFG_COHESION_STIFFNESS      = 3'd2;
  localparam logic [2:0] CFG_PENETRATION_DEPTH_MAX   = 3'd3;
  localparam logic [2:0] CFG_DISSIPATION             = 3'd4;
  localparam logic [2:0] CFG_CUTOFF_EPSILON          = 3'd5;

  localparam logic [63:0] KU_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MO_MAX = 64'h0000_0000_7FFF_FFFF;

  typedef struct packed {
    logic [30:0] k1;
    logic [30:0] k2;
    logic [30:0] kc;
    logic [15:0] phi;
    logic [30:0] eta;
    logic [15:0] eps;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             new_contact;
    logic             contact;
    logic [30:0]      ud;
    logic [62:0]      k2len;
    logic [45:0]      fc_mag;
    logic [45:0]      k1ud;
    logic [46:0]      damp;
    logic [15:0]      nx;
    logic [15:0]      ny;
    logic [15:0]      nz;
    logic             vn_sat;
  } item_t;

endpackage
`default_nettype wire

>>> rtl/plastic_contact_normal_force.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  contact_id .. normal_z
// out      output     out_valid_o/out_stall_i force_x/y/z, force_magnitude, flags
// cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
// Front end takes one item per cycle while in_stall_o is low, through two stages into
// a 4-entry queue. Back end handles one item at a time: an item in contact takes four
// 64-step radix-2 divisions, or five when the cohesive floor rewrites the peak overlap,
// on one shared divider; a zero divisor or k2 <= k1 skips its division. Asynchronous
// active-low reset clears control and config; the history memory is not cleared.
// out_stall_i holds the output register while it is valid, and the back end with it.
`default_nettype none
module plastic_contact_normal_force #(
  parameter int unsigned CONTACTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [9:0]         contact_id_i,
  input  logic               new_contact_i,
  input  logic signed [31:0] overlap_i,
  input  logic [30:0]        effective_radius_i,
  input  logic signed [31:0] rel_vel_x_i,
  input  logic signed [31:0] rel_vel_y_i,
  input  logic signed [31:0] rel_vel_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] force_x_o,
  output logic signed [47:0] force_y_o,
  output logic signed [47:0] force_z_o,
  output logic [46:0]        force_magnitude_o,
  output logic               in_contact_o,
  output logic               saturated_o
);
  import pcnf_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, head_item;
  logic  push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOADING_STIFFNESS:       cfg_q.k1  <= cfg_data_i;
        CFG_UNLOADING_STIFFNESS_MAX: cfg_q.k2  <= cfg_data_i;
        CFG_COHESION_STIFFNESS:      cfg_q.kc  <= cfg_data_i;
        CFG_PENETRATION_DEPTH_MAX:   cfg_q.phi <= cfg_data_i[15:0];
        CFG_DISSIPATION:             cfg_q.eta <= cfg_data_i;
        CFG_CUTOFF_EPSILON:          cfg_q.eps <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  pcnf_front #(.CONTACTS(CONTACTS)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .contact_id_i      (contact_id_i),
    .new_contact_i     (new_contact_i),
    .overlap_i         (overlap_i),
    .effective_radius_i(effective_radius_i),
    .rel_vel_x_i       (rel_vel_x_i),
    .rel_vel_y_i       (rel_vel_y_i),
    .rel_vel_z_i       (rel_vel_z_i),
    .normal_x_i        (normal_x_i),
    .normal_y_i        (normal_y_i),
    .normal_z_i        (normal_z_i),
    .full_i            (full),
    .push_o            (push),
    .item_o            (push_item)
  );

  pcnf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (head_item)
  );

  pcnf_back #(.CONTACTS(CONTACTS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .empty_i          (empty),
    .item_i           (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .force_x_o        (force_x_o),
    .force_y_o        (force_y_o),
    .force_z_o        (force_z_o),
    .force_magnitude_o(force_magnitude_o),
    .in_contact_o     (in_contact_o),
    .saturated_o      (saturated_o)
  );

endmodule
`default_nettype wire

>>> rtl/pcnf_div.sv
`default_nettype none
module pcnf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pcnf_pkg::DIV_W-1:0] num_i,
  input  logic [pcnf_pkg::DIV_W-1:0] den_i,
  output logic                      done_o,
  output logic [pcnf_pkg::DIV_W-1:0] quot_o
);
  import pcnf_pkg::*;

  localparam int unsigned CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_q, quo_q, dsr_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    fits  = trial >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      dsr_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? DIV_W'(trial - {1'b0, dsr_q}) : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

>>> rtl/pcnf_front.sv
`default_nettype none
module pcnf_front #(
  parameter int unsigned CONTACTS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcnf_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [9:0]            contact_id_i,
  input  logic                  new_contact_i,
  input  logic signed [31:0]    overlap_i,
  input  logic [30:0]           effective_radius_i,
  input  logic signed [31:0]    rel_vel_x_i,
  input  logic signed [31:0]    rel_vel_y_i,
  input  logic signed [31:0]    rel_vel_z_i,
  input  logic signed [15:0]    normal_x_i,
  input  logic signed [15:0]    normal_y_i,
  input  logic signed [15:0]    normal_z_i,
  input  logic                  full_i,
  output logic                  push_o,
  output pcnf_pkg::item_t       item_o
);
  import pcnf_pkg::*;

  localparam logic signed [34:0] VN_HI = 35'sd2147483647;
  localparam logic signed [34:0] VN_LO = -35'sd2147483648;

  logic                    adv;
  logic [9:0]              red;

  logic                    f1_valid_q;
  logic [IDX_W-1:0]        f1_idx_q;
  logic                    f1_new_q;
  logic signed [31:0]      f1_delta_q;
  logic [30:0]             f1_rad_q;
  logic signed [31:0]      f1_vx_q, f1_vy_q, f1_vz_q;
  logic signed [15:0]      f1_nx_q, f1_ny_q, f1_nz_q;

  logic                    f2_valid_q;
  logic [IDX_W-1:0]        f2_idx_q;
  logic                    f2_new_q, f2_contact_q;
  logic [30:0]             f2_ud_q;
  logic signed [47:0]      f2_px_q, f2_py_q, f2_pz_q;
  logic [31:0]             f2_len_q;
  logic [45:0]             f2_fc_q, f2_k1ud_q;
  logic signed [15:0]      f2_nx_q, f2_ny_q, f2_nz_q;

  logic [46:0]             len_p;
  logic [61:0]             kcud, k1ud;
  logic signed [49:0]      vsum;
  logic signed [34:0]      vn_w;
  logic signed [31:0]      vn;
  logic                    vn_sat;
  logic signed [63:0]      damp_p;

  assign adv        = !f2_valid_q || !full_i;
  assign in_stall_o = !adv;
  assign push_o     = f2_valid_q && !full_i;

  always_comb begin
    red = contact_id_i;
    for (int k = 9; k >= 0; k--) begin
      if (32'(red) >= (32'(CONTACTS) << k)) begin
        red = 10'(32'(red) - (32'(CONTACTS) << k));
      end
    end
  end

  always_comb begin
    len_p = 47'(f1_rad_q) * 47'(cfg_i.phi);
    kcud  = 62'(cfg_i.kc) * 62'(f1_delta_q[30:0]);
    k1ud  = 62'(cfg_i.k1) * 62'(f1_delta_q[30:0]);
  end

  always_comb begin
    vsum   = 50'(f2_px_q) + 50'(f2_py_q) + 50'(f2_pz_q);
    vn_w   = 35'(vsum >>> 15);
    vn_sat = 1'b0;
    if (vn_w > VN_HI) begin
      vn     = 32'sh7FFF_FFFF;
      vn_sat = 1'b1;
    end else if (vn_w < VN_LO) begin
      vn     = -32'sh8000_0000;
      vn_sat = 1'b1;
    end else begin
      vn = vn_w[31:0];
    end
    damp_p = 64'($signed({1'b0, cfg_i.eta})) * 64'(vn);
  end

  always_comb begin
    item_o.idx         = f2_idx_q;
    item_o.new_contact = f2_new_q;
    item_o.contact     = f2_contact_q;
    item_o.ud          = f2_ud_q;
    item_o.k2len       = 63'(cfg_i.k2) * 63'(f2_len_q);
    item_o.fc_mag      = f2_fc_q;
    item_o.k1ud        = f2_k1ud_q;
    item_o.damp        = 47'(damp_p >>> 16);
    item_o.nx          = f2_nx_q;
    item_o.ny          = f2_ny_q;
    item_o.nz          = f2_nz_q;
    item_o.vn_sat      = vn_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_idx_q   <= IDX_W'(red);
      f1_new_q   <= new_contact_i;
      f1_delta_q <= overlap_i;
      f1_rad_q   <= effective_radius_i;
      f1_vx_q    <= rel_vel_x_i;
      f1_vy_q    <= rel_vel_y_i;
      f1_vz_q    <= rel_vel_z_i;
      f1_nx_q    <= normal_x_i;
      f1_ny_q    <= normal_y_i;
      f1_nz_q    <= normal_z_i;

      f2_idx_q     <= f1_idx_q;
      f2_new_q     <= f1_new_q;
      f2_contact_q <= !f1_delta_q[31] && (f1_delta_q != '0);
      f2_ud_q      <= f1_delta_q[30:0];
      f2_px_q      <= 48'(f1_vx_q) * 48'(f1_nx_q);
      f2_py_q      <= 48'(f1_vy_q) * 48'(f1_ny_q);
      f2_pz_q      <= 48'(f1_vz_q) * 48'(f1_nz_q);
      f2_len_q     <= len_p[46:15];
      f2_fc_q      <= kcud[61:16];
      f2_k1ud_q    <= k1ud[61:16];
      f2_nx_q      <= f1_nx_q;
      f2_ny_q      <= f1_ny_q;
      f2_nz_q      <= f1_nz_q;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pcnf_fifo.sv
`default_nettype none
module pcnf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcnf_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pcnf_pkg::item_t item_o
);
  import pcnf_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  item_t         mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW + 1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("push into full queue");
`endif

endmodule
`default_nettype wire

>>> rtl/pcnf_back.sv
`default_nettype none
module pcnf_back #(
  parameter int unsigned CONTACTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcnf_pkg::cfg_t     cfg_i,
  input  logic               empty_i,
  input  pcnf_pkg::item_t    item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] force_x_o,
  output logic signed [47:0] force_y_o,
  output logic signed [47:0] force_z_o,
  output logic [46:0]        force_magnitude_o,
  output logic               in_contact_o,
  output logic               saturated_o
);
  import pcnf_pkg::*;

  localparam int unsigned AW = (CONTACTS > 1) ? $clog2(CONTACTS) : 1;
  localparam logic signed [49:0] F_HI = 50'sd140737488355327;
  localparam logic signed [49:0] F_LO = -50'sd140737488355327;

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_MUL, B_DSTART, B_DIV, B_POST, B_FIN, B_VEC, B_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_DS, OP_KU, OP_EQ, OP_F, OP_MO, OP_DMIN, OP_CUT
  } op_e;

  state_e             state_q;
  op_e                op_q;
  item_t              it_q;
  logic [31:0]        mem_q [CONTACTS];
  logic [31:0]        mem_rd_q;
  logic [30:0]        mo_q, dk_q, eq_q, dmin_q;
  logic [63:0]        ds_q, num_q, den_q;
  logic [31:0]        ku_q;
  logic signed [47:0] f_q;
  logic signed [63:0] fvx_q, fvy_q, fvz_q;
  logic               flag_q, out_valid_q;

  logic               out_free, mem_we, div_start, div_done, need_div;
  logic [63:0]        div_quot, den_sel, mul_res, draw, dsv, sat_mo;
  logic [31:0]        kuk1;
  logic [32:0]        kukc, kusum;
  logic signed [32:0] diff;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic [30:0]        mo0, mo_new;
  logic signed [63:0] fp64;
  logic signed [47:0] fprod, fcs;
  logic signed [49:0] fd;
  logic [63:0]        qk;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop_o     = (state_q == B_IDLE) && !empty_i;
  assign mem_we    = (state_q == B_OUT) && out_free && (it_q.contact || it_q.new_contact);
  assign div_start = (state_q == B_DSTART) && (den_q != '0);

  pcnf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    kuk1 = ku_q - {1'b0, cfg_i.k1};
    kukc = {1'b0, ku_q} + {2'b0, cfg_i.kc};
    diff = $signed({2'b0, it_q.ud}) - $signed({2'b0, eq_q});
    mo0  = it_q.new_contact ? '0 : mem_rd_q[30:0];
    mul_a    = '0;
    mul_b    = '0;
    den_sel  = '0;
    need_div = 1'b1;
    unique case (op_q)
      OP_DS: begin
        den_sel = {33'b0, dk_q};
      end
      OP_KU: begin
        mul_a   = {3'b0, dk_q};
        mul_b   = {3'b0, mo_q};
        den_sel = ds_q;
      end
      OP_EQ: begin
        mul_a   = {2'b0, kuk1};
        mul_b   = {3'b0, mo_q};
        den_sel = {32'b0, ku_q};
      end
      OP_F: begin
        mul_a    = {2'b0, ku_q};
        mul_b    = 34'(diff);
        need_div = 1'b0;
      end
      OP_MO: begin
        mul_a   = {1'b0, kukc};
        mul_b   = {3'b0, it_q.ud};
        den_sel = {32'b0, kuk1};
      end
      OP_DMIN: begin
        mul_a   = {2'b0, kuk1};
        mul_b   = {3'b0, mo_q};
        den_sel = {31'b0, kukc};
      end
      OP_CUT: begin
        mul_a    = {18'b0, cfg_i.eps};
        mul_b    = {3'b0, dmin_q};
        need_div = 1'b0;
      end
      default: need_div = 1'b0;
    endcase
    prod    = 68'(mul_a) * 68'(mul_b);
    mul_res = (op_q == OP_DS) ? {1'b0, it_q.k2len} : prod[63:0];

    draw   = (den_q == '0) ? ((num_q == '0) ? '0 : '1) : div_quot;
    dsv    = (dk_q == '0) ? '1 : div_quot;
    mo_new = mo_q;
    if (it_q.ud > mo_q) begin
      mo_new = (dsv < {33'b0, it_q.ud}) ? dsv[30:0] : it_q.ud;
    end
    sat_mo = (draw > MO_MAX) ? MO_MAX : draw;
    qk     = (draw > KU_MAX) ? KU_MAX : draw;
    kusum  = {1'b0, qk[31:0]} + {2'b0, cfg_i.k1};
    fp64   = $signed(num_q) >>> 16;
    fprod  = fp64[47:0];
    fcs    = 48'sd0 - $signed({2'b0, it_q.fc_mag});
    fd     = 50'(f_q) - 50'($signed(it_q.damp));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      op_q        <= OP_DS;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            it_q    <= item_i;
            state_q <= B_LOAD;
          end
        end
        B_LOAD: begin
          mo_q   <= mo0;
          flag_q <= it_q.contact && it_q.vn_sat;
          op_q   <= OP_DS;
          if (!it_q.contact) begin
            f_q     <= '0;
            state_q <= B_VEC;
          end else if (cfg_i.k2 > cfg_i.k1) begin
            dk_q    <= cfg_i.k2 - cfg_i.k1;
            state_q <= B_MUL;
          end else begin
            dk_q    <= '0;
            flag_q  <= 1'b1;
            state_q <= B_POST;
          end
        end
        B_MUL: begin
          num_q   <= mul_res;
          den_q   <= den_sel;
          state_q <= need_div ? B_DSTART : B_POST;
        end
        B_DSTART: begin
          state_q <= (den_q == '0) ? B_POST : B_DIV;
        end
        B_DIV: begin
          if (div_done) begin
            state_q <= B_POST;
          end
        end
        B_POST: begin
          state_q <= B_MUL;
          unique case (op_q)
            OP_DS: begin
              ds_q <= dsv;
              mo_q <= mo_new;
              op_q <= OP_KU;
            end
            OP_KU: begin
              if (draw > KU_MAX || kusum > KU_MAX[32:0]) begin
                flag_q <= 1'b1;
              end
              ku_q <= (kusum > KU_MAX[32:0]) ? KU_MAX[31:0] : kusum[31:0];
              op_q <= OP_EQ;
            end
            OP_EQ: begin
              if (draw > MO_MAX) begin
                flag_q <= 1'b1;
              end
              eq_q <= sat_mo[30:0];
              op_q <= OP_F;
            end
            OP_F: begin
              if (fprod < fcs) begin
                f_q  <= fcs;
                op_q <= OP_MO;
              end else begin
                f_q  <= fprod;
                op_q <= OP_DMIN;
              end
            end
            OP_MO: begin
              if (draw > MO_MAX) begin
                flag_q <= 1'b1;
              end
              mo_q <= sat_mo[30:0];
              op_q <= OP_DMIN;
            end
            OP_DMIN: begin
              if (draw > MO_MAX) begin
                flag_q <= 1'b1;
              end
              dmin_q <= sat_mo[30:0];
              op_q   <= OP_CUT;
            end
            OP_CUT: begin
              if (f_q < 0 && {17'b0, it_q.ud, 16'b0} < num_q) begin
                f_q <= $signed({2'b0, it_q.k1ud});
              end
              state_q <= B_FIN;
            end
            default: state_q <= B_IDLE;
          endcase
        end
        B_FIN: begin
          if (fd > F_HI) begin
            f_q    <= F_HI[47:0];
            flag_q <= 1'b1;
          end else if (fd < F_LO) begin
            f_q    <= F_LO[47:0];
            flag_q <= 1'b1;
          end else begin
            f_q <= fd[47:0];
          end
          state_q <= B_VEC;
        end
        B_VEC: begin
          fvx_q   <= 64'($signed(it_q.nx)) * 64'(f_q);
          fvy_q   <= 64'($signed(it_q.ny)) * 64'(f_q);
          fvz_q   <= 64'($signed(it_q.nz)) * 64'(f_q);
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            force_x_o         <= fvx_q[62:15];
            force_y_o         <= fvy_q[62:15];
            force_z_o         <= fvz_q[62:15];
            force_magnitude_o <= f_q[47] ? 47'(48'sd0 - f_q) : f_q[46:0];
            in_contact_o      <= it_q.contact;
            saturated_o       <= flag_q;
            state_q           <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mem_rd_q <= mem_q[item_i.idx[AW-1:0]];
    end
    if (mem_we) begin
      mem_q[it_q.idx[AW-1:0]] <= {1'b0, mo_q};
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> den_q != '0) else $error("divider started with zero divisor");
  a_ku_ge_k1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_POST && op_q == OP_EQ) |-> ku_q >= {1'b0, cfg_i.k1})
    else $error("unloading stiffness below loading stiffness");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none
module tb;
  import pcnf_pkg::*;

  localparam int unsigned NCONTACT = 1024;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam longint unsigned F_LIM = 64'h0000_7FFF_FFFF_FFFF;

  typedef struct {
    logic [9:0]         id;
    logic               newc;
    logic signed [31:0] ov;
    logic [30:0]        rad;
    logic signed [31:0] vx, vy, vz;
    logic signed [15:0] nx, ny, nz;
  } contact_item_t;

  typedef struct {
    logic signed [47:0] fx, fy, fz;
    logic [46:0]        fmag;
    logic               touch;
    logic               sat;
  } force_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = CFG_LOADING_STIFFNESS;
  logic [30:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [9:0] contact_id_i = '0;
  logic new_contact_i = 1'b0;
  logic signed [31:0] overlap_i = '0;
  logic [30:0] effective_radius_i = '0;
  logic signed [31:0] rel_vel_x_i = '0, rel_vel_y_i = '0, rel_vel_z_i = '0;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [47:0] force_x_o, force_y_o, force_z_o;
  logic [46:0] force_magnitude_o;
  logic in_contact_o, saturated_o;

  plastic_contact_normal_force uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .contact_id_i, .new_contact_i, .overlap_i,
    .effective_radius_i, .rel_vel_x_i, .rel_vel_y_i, .rel_vel_z_i,
    .normal_x_i, .normal_y_i, .normal_z_i,
    .out_valid_o, .out_stall_i, .force_x_o, .force_y_o, .force_z_o,
    .force_magnitude_o, .in_contact_o, .saturated_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  longint unsigned k1_q, k2_q, kc_q, phi_q, eta_q, eps_q;
  logic [31:0] peak_overlap [NCONTACT];
  bit id_seen [NCONTACT];

  contact_item_t pend_q [$];
  force_t force_q [$];
  bit idle_en = 1'b1;
  bit hold_start = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned snd_gap = 0, rcv_gap = 0;
  int unsigned n_err = 0, n_res = 0, n_touch = 0, n_sat = 0, n_cfg = 0;
  longint unsigned cycles = 0;

  function automatic longint unsigned quot_sat(longint unsigned num, longint unsigned den,
                                               longint unsigned lim, inout bit flag);
    longint unsigned q;
    if (den == 0) begin
      if (num == 0) return 0;
      flag = 1'b1;
      return lim;
    end
    q = num / den;
    if (q > lim) begin
      flag = 1'b1;
      return lim;
    end
    return q;
  endfunction

  function automatic force_t predict_force(contact_item_t it);
    force_t r;
    bit flag;
    longint unsigned ud, len, dk, ds, mo, ku, eq, dmin;
    longint vn, f, fc, damp, delta;
    r = '{default: '0};
    flag = 1'b0;
    if (it.newc) peak_overlap[it.id] = '0;
    if (it.ov <= 0) return r;
    delta = longint'(it.ov);
    ud = longint'(it.ov);
    vn = (longint'(it.vx) * longint'(it.nx) + longint'(it.vy) * longint'(it.ny)
          + longint'(it.vz) * longint'(it.nz)) >>> 15;
    if (vn > 64'sd2147483647) begin vn = 64'sd2147483647; flag = 1'b1; end
    if (vn < -64'sd2147483648) begin vn = -64'sd2147483648; flag = 1'b1; end
    len = (phi_q * longint'(it.rad)) >> 15;
    if (k2_q > k1_q) begin
      dk = k2_q - k1_q;
      ds = (k2_q * len) / dk;
    end else begin
      dk = 0;
      ds = '1;
      flag = 1'b1;
    end
    mo = peak_overlap[it.id];
    if (ud > mo) mo = (ds < ud) ? ds : ud;
    ku = k1_q + quot_sat(dk * mo, ds, KU_MAX, flag);
    if (ku > KU_MAX) begin ku = KU_MAX; flag = 1'b1; end
    eq = quot_sat((ku - k1_q) * mo, ku, MO_MAX, flag);
    f = (longint'(ku) * (delta - longint'(eq))) >>> 16;
    fc = -longint'((kc_q * ud) >> 16);
    if (f < fc) begin
      mo = quot_sat((ku + kc_q) * ud, ku - k1_q, MO_MAX, flag);
      f = fc;
    end
    dmin = quot_sat((ku - k1_q) * mo, ku + kc_q, MO_MAX, flag);
    if (f < 0 && (ud << 16) < eps_q * dmin) f = longint'((k1_q * ud) >> 16);
    damp = (longint'(eta_q) * vn) >>> 16;
    f = f - damp;
    if (f > longint'(F_LIM)) begin f = longint'(F_LIM); flag = 1'b1; end
    if (f < -longint'(F_LIM)) begin f = -longint'(F_LIM); flag = 1'b1; end
    peak_overlap[it.id] = mo[31:0];
    r.fx = 48'((longint'(it.nx) * f) >>> 15);
    r.fy = 48'((longint'(it.ny) * f) >>> 15);
    r.fz = 48'((longint'(it.nz) * f) >>> 15);
    r.fmag = 47'((f < 0) ? -f : f);
    r.touch = 1'b1;
    r.sat = flag;
    return r;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        force_q.push_back(predict_force(pend_q[0]));
        void'(pend_q.pop_front());
      end
      if (snd_gap > 0) begin
        snd_gap <= snd_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() > 0) begin
        if (idle_en && $urandom_range(0, 7) == 0) begin
          snd_gap <= $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else begin
          automatic contact_item_t nx_it = pend_q[0];
          in_valid_i <= 1'b1;
          contact_id_i <= nx_it.id;
          new_contact_i <= nx_it.newc;
          overlap_i <= nx_it.ov;
          effective_radius_i <= nx_it.rad;
          rel_vel_x_i <= nx_it.vx;
          rel_vel_y_i <= nx_it.vy;
          rel_vel_z_i <= nx_it.vz;
          normal_x_i <= nx_it.nx;
          normal_y_i <= nx_it.ny;
          normal_z_i <= nx_it.nz;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_start) hold_cnt <= 3000;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_res <= n_res + 1;
        if (in_contact_o) n_touch <= n_touch + 1;
        if (saturated_o) n_sat <= n_sat + 1;
        if (force_q.size() == 0) begin
          n_err = n_err + 1;
          if (n_err <= 10) $display("ERROR: unexpected result, force_x %0d", force_x_o);
        end else begin
          automatic force_t e = force_q.pop_front();
          if (e.fx !== force_x_o || e.fy !== force_y_o || e.fz !== force_z_o ||
              e.fmag !== force_magnitude_o || e.touch !== in_contact_o ||
              e.sat !== saturated_o) begin
            n_err = n_err + 1;
            if (n_err <= 10)
              $display("ERROR: exp f=%0d/%0d/%0d |f|=%0d c=%b s=%b got %0d/%0d/%0d %0d %b %b",
                       e.fx, e.fy, e.fz, e.fmag, e.touch, e.sat, force_x_o, force_y_o,
                       force_z_o, force_magnitude_o, in_contact_o, saturated_o);
          end
        end
      end
      if (rcv_gap > 0) begin
        rcv_gap <= rcv_gap - 1;
        out_stall_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        rcv_gap <= $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (hold_cnt > 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, longint unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[30:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(longint unsigned k1, longint unsigned k2, longint unsigned kc,
                            longint unsigned phi, longint unsigned eta, longint unsigned eps);
    write_reg(CFG_LOADING_STIFFNESS, k1);
    write_reg(CFG_UNLOADING_STIFFNESS_MAX, k2);
    write_reg(CFG_COHESION_STIFFNESS, kc);
    write_reg(CFG_PENETRATION_DEPTH_MAX, phi);
    write_reg(CFG_DISSIPATION, eta);
    write_reg(CFG_CUTOFF_EPSILON, eps);
    k1_q = k1 & 64'h7FFF_FFFF; k2_q = k2 & 64'h7FFF_FFFF; kc_q = kc & 64'h7FFF_FFFF;
    phi_q = phi & 64'hFFFF; eta_q = eta & 64'h7FFF_FFFF; eps_q = eps & 64'hFFFF;
    n_cfg++;
  endtask

  task automatic push_item(int unsigned id, bit newc, logic signed [31:0] ov,
                           logic [30:0] rad, logic signed [31:0] vx, logic signed [31:0] vy,
                           logic signed [31:0] vz, logic signed [15:0] nx,
                           logic signed [15:0] ny, logic signed [15:0] nz);
    contact_item_t it;
    if (!id_seen[id]) newc = 1'b1;
    id_seen[id] = 1'b1;
    it = '{id: id[9:0], newc: newc, ov: ov, rad: rad, vx: vx, vy: vy, vz: vz,
           nx: nx, ny: ny, nz: nz};
    pend_q.push_back(it);
  endtask

  task automatic push_noise();
    push_item($urandom_range(0, NCONTACT - 1), $urandom_range(0, 1), $urandom,
              31'($urandom), $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  // one contact: approach, load, unload, pull apart; small velocities, random normal components
  task automatic push_contact(int unsigned steps);
    int unsigned id, peak, rad, k;
    int ov;
    bit broken;
    id = $urandom_range(0, NCONTACT - 1);
    rad = $urandom_range(1 << 14, 1 << 18);
    peak = $urandom_range(1, rad / 4);
    broken = ($urandom_range(0, 9) == 0);
    for (k = 0; k < steps; k++) begin
      if (k < steps / 2) ov = int'((longint'(peak) * (k + 1)) / (steps / 2 + 1));
      else ov = peak - int'((longint'(peak) * 5 * (k - steps / 2)) / (4 * (steps - steps / 2)));
      ov = ov + int'($urandom_range(0, 64)) - 32;
      push_item(id, (k == 0) && !broken, ov, 31'(rad),
                int'($urandom_range(0, 1 << 18)) - (1 << 17),
                int'($urandom_range(0, 1 << 18)) - (1 << 17),
                int'($urandom_range(0, 1 << 18)) - (1 << 17),
                16'(int'($urandom_range(0, 65535)) - 32768),
                16'(int'($urandom_range(0, 8192)) - 4096),
                16'(int'($urandom_range(0, 65535)) - 32768));
    end
  endtask

  task automatic run_phase(int unsigned n);
    int unsigned cnt;
    cnt = 0;
    while (cnt < n) begin
      @(negedge clk_i);
      if ($urandom_range(0, 4) == 0) begin
        push_noise();
        cnt++;
      end else begin
        automatic int unsigned s = $urandom_range(4, 12);
        push_contact(s);
        cnt += s;
      end
      wait (pend_q.size() < 8);
    end
  endtask

  task automatic drain();
    wait (pend_q.size() == 0 && force_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic realistic_config();
    longint unsigned k1;
    k1 = $urandom_range(1 << 16, 1 << 24);
    set_config(k1, k1 * $urandom_range(2, 6), k1 / $urandom_range(1, 4),
               $urandom_range(1000, 20000), $urandom_range(0, 1 << 18),
               $urandom_range(0, 65535));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_config(64'd6553600, 64'd32768000, 64'd3276800, 64'd3277, 64'd65536, 64'd16384);
    @(negedge clk_i);
    // corners of every field
    push_item(0, 1, 0, 65536, 0, 0, 0, 32767, 0, 0);
    push_item(1023, 1, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
              0, 16'sh8000, 16'sh7FFF, 16'sh8000);
    push_item(0, 0, 32'sd1, 65536, 0, 0, 0, 32767, 0, 0);
    push_item(0, 0, 32'sd6553, 65536, 1000, -2000, 0, 0, 32767, 0);
    push_item(0, 0, 32'sd3000, 65536, 0, 0, 0, 0, 0, 32767);
    push_item(0, 0, 32'sd10, 65536, 0, 0, 0, 23170, 23170, 0);
    push_item(0, 0, 32'sd1, 65536, 0, 0, 0, 23170, 23170, 0);
    push_item(0, 0, 32'sd0, 65536, 0, 0, 0, 32767, 0, 0);
    push_item(5, 1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_item(6, 1, 32'sh7FFF_FFFF, 31'd0, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 16'sh8000, 16'sh8000, 16'sh8000);
    push_item(7, 1, 32'sd100, 31'd0, 0, 0, 0, 16'sh7FFF, 0, 0);
    push_item(7, 0, -32'sd5, 65536, 0, 0, 0, 16'sh7FFF, 0, 0);
    push_item(7, 1, 32'sd20, 65536, 0, 0, 0, 16'sh7FFF, 0, 0);
    drain();
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    run_phase(300);
    drain();
    // stiffness order violated, zero registers
    set_config(64'd6553600, 64'd6553600, 64'd0, 64'd0, 64'd0, 64'd0);
    push_item(9, 1, 32'sd5000, 65536, 0, 0, 0, 32767, 0, 0);
    push_item(9, 0, 32'sd100, 65536, 0, 0, 0, 32767, 0, 0);
    run_phase(120);
    drain();
    set_config(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
    run_phase(120);
    drain();
    set_config(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'hFFFF, 64'h7FFF_FFFF,
               64'hFFFF);
    run_phase(150);
    drain();
    set_config(64'd1, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'hFFFF, 64'h7FFF_FFFF, 64'hFFFF);
    run_phase(150);
    drain();
    repeat (4) begin
      realistic_config();
      run_phase(200);
      drain();
    end
    idle_en = 1'b0;
    realistic_config();
    run_phase(150);
    drain();
    repeat (400) @(posedge clk_i);
    $display("Checked %0d results (%0d in contact, %0d saturated) over %0d register settings.",
             n_res, n_touch, n_sat, n_cfg);
    if (n_err == 0 && force_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", n_err);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> plastic_contact_normal_force.f
rtl/pcnf_pkg.sv
rtl/pcnf_div.sv
rtl/pcnf_front.sv
rtl/pcnf_fifo.sv
rtl/pcnf_back.sv
rtl/plastic_contact_normal_force.sv
tb/sv/tb.sv
